// ===== hdl/mpsm_pkg.sv =====
// ----------------------------------------------------------------------------
// mpsm_pkg: shared definitions for the multi-pattern stream matcher
// Sizes, opcodes, beat payload structs and the match queue entry type.
// ----------------------------------------------------------------------------
package mpsm_pkg;

  localparam int PATTERN_SLOTS       = 8;
  localparam int MAX_PATTERN_LENGTH  = 16;
  localparam int DEFAULT_QUEUE_DEPTH = 4;

  localparam int SLOT_W     = $clog2(PATTERN_SLOTS);
  localparam int IDX_W      = $clog2(MAX_PATTERN_LENGTH);
  localparam int LEN_W      = $clog2(MAX_PATTERN_LENGTH + 1);
  localparam int HIST_DEPTH = MAX_PATTERN_LENGTH - 1;
  localparam int BYTE_W     = 8;
  localparam int POS_W      = 32;

  typedef enum logic [1:0] {
    OP_LOAD_BYTE  = 2'd0,
    OP_SET_LENGTH = 2'd1,
    OP_TEXT_BYTE  = 2'd2
  } opcode_t;

  typedef logic [PATTERN_SLOTS-1:0] slot_mask_t;
  typedef logic [LEN_W-1:0]         len_t;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [SLOT_W-1:0] pattern_slot;
    logic [IDX_W-1:0]  byte_index;
    logic [BYTE_W-1:0] byte_value;
    len_t              pattern_length;
    logic              new_text;
  } item_t;

  typedef struct packed {
    logic [SLOT_W-1:0] matched_slot;
    logic [POS_W-1:0]  start_position;
    logic              last;
  } result_t;

  typedef struct packed {
    slot_mask_t                 mask;
    logic [POS_W-1:0]           position;
    len_t [PATTERN_SLOTS-1:0]   lens;
  } match_entry_t;

endpackage

// ===== hdl/multi_pattern_stream_matcher.sv =====
// ----------------------------------------------------------------------------
// multi_pattern_stream_matcher: exact multi-pattern search over a byte stream
// Pattern bytes and lengths are loaded by item beats; each text byte beat
// yields one result beat per slot whose pattern ends at that byte.
//
//   channel   direction   handshake                   payload
//   item      in          item_valid / item_ready     item_t
//   result    out         result_valid / result_ready result_t
//
// One item beat is taken every cycle while the match queue has room.
// A text byte with n matches gives n result beats, one per cycle while
// result_ready is high, after passing the match queue and the drain register.
// The match queue holds QUEUE_DEPTH matching bytes; item_ready falls only
// when it is full. Reset clears lengths, history, position and the queue;
// pattern bytes keep their contents.
// ----------------------------------------------------------------------------
module multi_pattern_stream_matcher import mpsm_pkg::*; #(
  parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_ready,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t result
);

  logic         full;
  logic         push;
  match_entry_t push_entry;
  logic         pop;
  logic         head_valid;
  match_entry_t head;

  mpsm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .full       (full),
    .push       (push),
    .push_entry (push_entry)
  );

  mpsm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  mpsm_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head         (head),
    .pop          (pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

// ===== hdl/mpsm_front.sv =====
// ----------------------------------------------------------------------------
// mpsm_front: item intake and match detection
// Holds the pattern slots, slot lengths, text history and position. Every
// text byte is compared against all slots at once; a nonzero hit mask is
// pushed into the match queue together with the position and lengths.
// ----------------------------------------------------------------------------
module mpsm_front import mpsm_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         item_valid,
  output logic         item_ready,
  input  item_t        item,
  input  logic         full,
  output logic         push,
  output match_entry_t push_entry
);

  logic [BYTE_W-1:0]        pattern [PATTERN_SLOTS][MAX_PATTERN_LENGTH];
  len_t [PATTERN_SLOTS-1:0] lens;
  logic [BYTE_W-1:0]        hist [HIST_DEPTH];
  logic [POS_W-1:0]         bytes_seen;

  logic [BYTE_W-1:0] win [MAX_PATTERN_LENGTH];
  logic [POS_W-1:0]  pos_eff;
  slot_mask_t        mask;
  logic              accept;
  logic              is_text;

  assign item_ready = !full;
  assign accept     = item_valid && item_ready;
  assign is_text    = (item.opcode == OP_TEXT_BYTE);
  assign pos_eff    = item.new_text ? '0 : bytes_seen;

  always_comb begin
    win[0] = item.byte_value;
    for (int j = 1; j < MAX_PATTERN_LENGTH; j++) begin
      win[j] = item.new_text ? '0 : hist[j-1];
    end
  end

  always_comb begin
    len_t j;
    logic hit;
    for (int s = 0; s < PATTERN_SLOTS; s++) begin
      hit = (lens[s] != '0) && (pos_eff >= (POS_W'(lens[s]) - POS_W'(1)));
      for (int i = 0; i < MAX_PATTERN_LENGTH; i++) begin
        j = lens[s] - LEN_W'(i) - LEN_W'(1);
        if (LEN_W'(i) < lens[s] && pattern[s][i] != win[j[IDX_W-1:0]]) begin
          hit = 1'b0;
        end
      end
      mask[s] = hit;
    end
  end

  assign push       = accept && is_text && (mask != '0);
  assign push_entry = '{mask: mask, position: pos_eff, lens: lens};

  always_ff @(posedge clk) begin
    if (accept && item.opcode == OP_LOAD_BYTE && int'(item.pattern_slot) < PATTERN_SLOTS
        && int'(item.byte_index) < MAX_PATTERN_LENGTH) begin
      pattern[item.pattern_slot][item.byte_index] <= item.byte_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lens       <= '0;
      bytes_seen <= '0;
      for (int k = 0; k < HIST_DEPTH; k++) begin
        hist[k] <= '0;
      end
    end else if (accept) begin
      unique case (opcode_t'(item.opcode))
        OP_LOAD_BYTE: begin
        end
        OP_SET_LENGTH: begin
          if (int'(item.pattern_slot) < PATTERN_SLOTS) begin
            lens[item.pattern_slot] <=
              (item.pattern_length > LEN_W'(MAX_PATTERN_LENGTH)) ?
              LEN_W'(MAX_PATTERN_LENGTH) : item.pattern_length;
          end
        end
        OP_TEXT_BYTE: begin
          for (int k = 0; k < HIST_DEPTH; k++) begin
            hist[k] <= win[k];
          end
          bytes_seen <= (pos_eff == '1) ? pos_eff : pos_eff + POS_W'(1);
        end
        default: begin
        end
      endcase
    end
  end

  a_new_text_restarts: assert property (@(posedge clk) disable iff (rst)
    accept && is_text && item.new_text |=> bytes_seen == POS_W'(1))
    else $error("new text did not restart the position");

endmodule

// ===== hdl/mpsm_queue.sv =====
// ----------------------------------------------------------------------------
// mpsm_queue: match queue between intake and result drain
// A small circular buffer of hit masks with their positions and lengths.
// ----------------------------------------------------------------------------
module mpsm_queue import mpsm_pkg::*; #(
  parameter int DEPTH = DEFAULT_QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  match_entry_t push_entry,
  output logic         full,
  input  logic         pop,
  output logic         head_valid,
  output match_entry_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  match_entry_t     entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full       = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("push into a full match queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> head_valid)
    else $error("pop from an empty match queue");

  a_empty_pointers: assert property (@(posedge clk) disable iff (rst)
    count == '0 |-> wr_ptr == rd_ptr)
    else $error("empty match queue with unequal pointers");

endmodule

// ===== hdl/mpsm_back.sv =====
// ----------------------------------------------------------------------------
// mpsm_back: result drain
// Takes one queued hit mask at a time and sends one result beat per set
// bit, lowest slot first, flagging the beat of the highest set bit as last.
// ----------------------------------------------------------------------------
module mpsm_back import mpsm_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         head_valid,
  input  match_entry_t head,
  output logic         pop,
  output logic         result_valid,
  input  logic         result_ready,
  output result_t      result
);

  logic                     busy;
  slot_mask_t               pending;
  logic [POS_W-1:0]         position;
  len_t [PATTERN_SLOTS-1:0] lens;

  logic [SLOT_W-1:0] sel;
  slot_mask_t        rest;
  logic              is_last;
  logic              fire;

  always_comb begin
    sel = '0;
    for (int i = PATTERN_SLOTS - 1; i >= 0; i--) begin
      if (pending[i]) begin
        sel = SLOT_W'(i);
      end
    end
  end

  assign rest    = pending & (pending - slot_mask_t'(1));
  assign is_last = (rest == '0);
  assign fire    = busy && (!result_valid || result_ready);
  assign pop     = head_valid && (!busy || (fire && is_last));

  always_ff @(posedge clk) begin
    if (fire) begin
      result <= '{matched_slot:   sel,
                  start_position: position - POS_W'(lens[sel]) + POS_W'(1),
                  last:           is_last};
    end
    if (pop) begin
      position <= head.position;
      lens     <= head.lens;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy         <= 1'b0;
      pending      <= '0;
      result_valid <= 1'b0;
    end else begin
      if (fire) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      if (pop) begin
        busy    <= 1'b1;
        pending <= head.mask;
      end else if (fire) begin
        pending <= rest;
        if (is_last) begin
          busy <= 1'b0;
        end
      end
    end
  end

  a_busy_has_work: assert property (@(posedge clk) disable iff (rst)
    busy |-> pending != '0)
    else $error("drain busy with no pending match");

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench for the multi-pattern stream matcher
// Loads patterns into slots and streams text bytes through the item channel,
// keeps a shadow of the slot contents, history and text position to predict
// the match beats, and compares every result beat field by field in order.
// ----------------------------------------------------------------------------
module tb;
  import mpsm_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    item_valid = 1'b0;
  logic    item_ready;
  item_t   item = '0;
  logic    result_valid;
  logic    result_ready = 1'b0;
  result_t result;

  multi_pattern_stream_matcher u_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  always #2 clk = ~clk;

  item_t   beats_to_send[$];
  result_t pending_matches[$];
  int      error_count = 0;
  int      total_beats = 0;
  int      beats_taken = 0;
  int      send_idle = 0;
  int      drain_idle = 0;
  logic    idle_ok;

  // Shadow of the block used for prediction.
  logic [BYTE_W-1:0] pat_mem [PATTERN_SLOTS][MAX_PATTERN_LENGTH];
  len_t              slot_len [PATTERN_SLOTS];
  logic [BYTE_W-1:0] hist [HIST_DEPTH];
  logic [POS_W-1:0]  text_pos;

  // Stimulus-side view of the slots, so that text can embed the patterns and
  // no slot is enabled over pattern bytes that were never written.
  logic [BYTE_W-1:0] gen_pat [PATTERN_SLOTS][MAX_PATTERN_LENGTH];
  int                gen_len [PATTERN_SLOTS];

  assign idle_ok = (beats_taken < total_beats - 30) && ((beats_taken / 40) % 4 != 3);

  function automatic item_t random_beat();
    logic [31:0] r;
    r = $urandom;
    return r[$bits(item_t)-1:0];
  endfunction

  function automatic logic [7:0] pick_byte();
    if ($urandom_range(0, 4) != 0) return 8'(8'h61 + $urandom_range(0, 2));
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic load_byte(input int slot, input int idx, input logic [7:0] val);
    item_t it;
    it = random_beat();
    it.opcode       = OP_LOAD_BYTE;
    it.pattern_slot = SLOT_W'(slot);
    it.byte_index   = IDX_W'(idx);
    it.byte_value   = val;
    gen_pat[slot][idx] = val;
    beats_to_send.push_back(it);
  endtask

  task automatic set_length(input int slot, input int raw_len);
    item_t it;
    it = random_beat();
    it.opcode         = OP_SET_LENGTH;
    it.pattern_slot   = SLOT_W'(slot);
    it.pattern_length = len_t'(raw_len);
    gen_len[slot] = (raw_len > MAX_PATTERN_LENGTH) ? MAX_PATTERN_LENGTH : raw_len;
    beats_to_send.push_back(it);
  endtask

  task automatic text_byte(input logic [7:0] val, input bit fresh);
    item_t it;
    it = random_beat();
    it.opcode     = OP_TEXT_BYTE;
    it.byte_value = val;
    it.new_text   = fresh;
    beats_to_send.push_back(it);
  endtask

  task automatic unused_beat();
    item_t it;
    it = random_beat();
    it.opcode = OP_UNUSED;
    beats_to_send.push_back(it);
  endtask

  task automatic track_item(input item_t it);
    int unsigned n;
    bit          hit;
    result_t     found[$];
    result_t     r;
    case (it.opcode)
      OP_LOAD_BYTE: pat_mem[it.pattern_slot][it.byte_index] = it.byte_value;
      OP_SET_LENGTH: begin
        slot_len[it.pattern_slot] = (it.pattern_length > MAX_PATTERN_LENGTH) ?
                                    len_t'(MAX_PATTERN_LENGTH) : it.pattern_length;
      end
      OP_TEXT_BYTE: begin
        if (it.new_text) begin
          foreach (hist[k]) hist[k] = '0;
          text_pos = '0;
        end
        for (int s = 0; s < PATTERN_SLOTS; s++) begin
          n = slot_len[s];
          hit = 1'b0;
          if (n != 0 && ({1'b0, text_pos} + 33'd1 >= 33'(n))) begin
            hit = (pat_mem[s][n-1] == it.byte_value);
            for (int k = 1; k < n; k++) begin
              if (pat_mem[s][n-1-k] != hist[k-1]) hit = 1'b0;
            end
          end
          if (hit) begin
            r.matched_slot   = SLOT_W'(s);
            r.start_position = text_pos - POS_W'(n - 1);
            r.last           = 1'b0;
            found.push_back(r);
          end
        end
        foreach (found[i]) begin
          r = found[i];
          r.last = (i == found.size() - 1);
          pending_matches.push_back(r);
        end
        for (int k = HIST_DEPTH - 1; k > 0; k--) hist[k] = hist[k-1];
        hist[0] = it.byte_value;
        if (text_pos != '1) text_pos = text_pos + 1'b1;
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      send_idle = 0;
    end else begin
      if (item_valid && item_ready) begin
        track_item(item);
        beats_taken++;
      end
      if (!item_valid || item_ready) begin
        if (!idle_ok) send_idle = 0;
        else if (send_idle == 0 && $urandom_range(0, 9) == 0) send_idle = $urandom_range(1, 16);
        if (send_idle > 0 || beats_to_send.size() == 0) begin
          if (send_idle > 0) send_idle--;
          item_valid <= 1'b0;
        end else begin
          item       <= beats_to_send.pop_front();
          item_valid <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      result_ready <= 1'b0;
      drain_idle = 0;
    end else begin
      if (result_valid && result_ready) begin
        if (pending_matches.size() == 0) begin
          error_count++;
          if (error_count <= 10)
            $display("unexpected match beat: slot %0d start %0d last %0b",
                     result.matched_slot, result.start_position, result.last);
        end else begin
          want = pending_matches.pop_front();
          if (result.matched_slot !== want.matched_slot ||
              result.start_position !== want.start_position ||
              result.last !== want.last) begin
            error_count++;
            if (error_count <= 10)
              $display("match mismatch: expected slot %0d start %0d last %0b, got slot %0d start %0d last %0b",
                       want.matched_slot, want.start_position, want.last,
                       result.matched_slot, result.start_position, result.last);
          end
        end
      end
      if (!idle_ok) drain_idle = 0;
      else if (drain_idle == 0 && $urandom_range(0, 9) == 0) drain_idle = $urandom_range(1, 16);
      if (drain_idle > 0) begin
        drain_idle--;
        result_ready <= 1'b0;
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  initial begin
    int rand_beats;
    int round;
    int slot;
    int raw_len;
    int eff;
    int seg;
    int pick;

    foreach (slot_len[s]) begin
      slot_len[s] = '0;
      gen_len[s]  = 0;
    end
    foreach (hist[k]) hist[k] = '0;
    text_pos = '0;

    // Directed opening: empty pattern set, single-byte and three-byte patterns,
    // a text too short for its pattern, simultaneous matches, disabling a slot,
    // reloading a slot in the middle of a text and the unused opcode.
    unused_beat();
    text_byte(8'h5A, 1'b0);
    load_byte(0, 0, 8'hFF);
    set_length(0, 1);
    load_byte(7, 0, 8'h00);
    load_byte(7, 1, 8'h00);
    load_byte(7, 2, 8'hFF);
    set_length(7, 3);
    text_byte(8'hFF, 1'b1);
    text_byte(8'h00, 1'b0);
    text_byte(8'h00, 1'b0);
    text_byte(8'hFF, 1'b0);
    set_length(0, 0);
    text_byte(8'hFF, 1'b0);
    load_byte(7, 0, 8'hFF);
    load_byte(7, 1, 8'hFF);
    text_byte(8'hFF, 1'b0);
    load_byte(3, 0, 8'h41);
    set_length(3, 1);
    set_length(0, 1);
    text_byte(8'hFF, 1'b0);
    text_byte(8'h41, 1'b0);
    unused_beat();

    rand_beats = beats_to_send.size();
    round = 0;
    while (rand_beats < 120) begin
      repeat ($urandom_range(1, 3)) begin
        slot = $urandom_range(0, PATTERN_SLOTS - 1);
        pick = $urandom_range(0, 9);
        if (round == 0) raw_len = 31;
        else if (pick < 8) raw_len = $urandom_range(1, 5);
        else if (pick == 8) raw_len = $urandom_range(6, 16);
        else raw_len = $urandom_range(17, 31);
        eff = (raw_len > MAX_PATTERN_LENGTH) ? MAX_PATTERN_LENGTH : raw_len;
        for (int i = 0; i < eff; i++) load_byte(slot, i, pick_byte());
        set_length(slot, raw_len);
        rand_beats += eff + 1;
        round++;
      end
      case ($urandom_range(0, 5))
        0: unused_beat();
        1: begin
          set_length($urandom_range(0, PATTERN_SLOTS - 1), 0);
          rand_beats++;
        end
        2: begin
          slot = $urandom_range(0, PATTERN_SLOTS - 1);
          if (gen_len[slot] != 0) begin
            load_byte(slot, $urandom_range(0, gen_len[slot] - 1), pick_byte());
            rand_beats++;
          end
        end
        default: ;
      endcase
      seg = $urandom_range(8, 20);
      while (seg > 0) begin
        slot = $urandom_range(0, PATTERN_SLOTS - 1);
        if ($urandom_range(0, 1) == 0 && gen_len[slot] != 0) begin
          for (int i = 0; i < gen_len[slot]; i++) text_byte(gen_pat[slot][i], 1'b0);
          seg -= gen_len[slot];
          rand_beats += gen_len[slot];
        end else begin
          text_byte(pick_byte(), $urandom_range(0, 19) == 0);
          seg--;
          rand_beats++;
        end
      end
    end
    total_beats = beats_to_send.size();

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    while (beats_to_send.size() != 0 || item_valid) @(posedge clk);
    while (pending_matches.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
